>>> sv/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SGS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SGS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SGS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/sgs_pkg.sv
package sgs_pkg;
  localparam int SampleW = 24;
  localparam int CoefW   = 18;
  localparam int AccW    = 48;
  localparam int PosW    = 32;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_OUT  = 4'b0100,
    ST_BYP  = 4'b1000
  } state_t;

  function automatic longint gp(input int k, input longint t, input longint m);
    case (k)
      0: return 1;
      1: return t;
      2: return 3*t*t - m*(m+1);
      3: return 5*t*t*t - (3*m*m + 3*m - 1)*t;
      4: return 35*t*t*t*t - 5*(6*m*m + 6*m - 5)*t*t + 3*m*(m*m - 1)*(m + 2);
      default: return 0;
    endcase
  endfunction

  // num / den with 40 fraction bits, truncated toward zero, shift-subtract
  function automatic longint ratio_f(input longint num, input longint den);
    logic [63:0]  mag;
    logic [103:0] dvd;
    logic [64:0]  rem;
    logic [63:0]  quo;
    int b;
    mag = (num < 0) ? 64'(-num) : 64'(num);
    dvd = {mag, 40'b0};
    rem = '0;
    quo = '0;
    for (b = 103; b >= 0; b--) begin
      rem = {rem[63:0], dvd[b]};
      quo = {quo[62:0], 1'b0};
      if (rem >= {1'b0, 64'(den)}) begin
        rem = rem - {1'b0, 64'(den)};
        quo[0] = 1'b1;
      end
    end
    return (num < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  // coefficient of row i, tap j for window w, degree d (terms above degree 4
  // are not summed, so d is in effect limited to 4 here)
  function automatic logic signed [CoefW-1:0] coef_f(input int w, input int i,
                                                     input int j, input int d);
    longint m, num, acc, c, sk, pi, pj, t, den;
    int k, q;
    m = (w - 1) >>> 1;
    acc = 0;
    for (k = 0; k <= 4; k++) begin
      if (k <= d) begin
        sk = 0;
        for (q = 0; q < 63; q++) begin
          if (q < w) begin
            t = q - m;
            pi = gp(k, t, m);
            sk = sk + pi * pi;
          end
        end
        pi = gp(k, i - m, m);
        pj = gp(k, j - m, m);
        num = pi * pj;
        den = sk;
        if (den != 0) acc = acc + ratio_f(num, den);
      end
    end
    c = acc + (longint'(1) << 23);
    c = (c >= 0) ? (c >>> 24) : -(((-c) + (longint'(1) << 24) - 1) >>> 24);
    if (c > 131071) c = 131071;
    if (c < -131072) c = -131072;
    return c[CoefW-1:0];
  endfunction

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctl_t;
endpackage

>>> sv/savitzky_golay_stream_smoother_core.sv
// channel | ports                                   | direction
// in      | in_valid, in_stall, in_sample           | beat in
// out     | out_valid, out_stall, out_position,     | beat out
//         | out_smoothed_value, out_last_of_run     |
// one sample is accepted in idle, then each result is computed on the shared
// multiplier: the window products in the mac state, a drain that finishes the
// sum, then the output state; bypass beats pass through the bypass state
// a result holds in the accumulator while out_stall is high
// reset clears count, fill level and the sequencer; the history is not cleared
`include "assert_macros.svh"
module savitzky_golay_stream_smoother_core #(
  parameter int SPAN   = 9,
  parameter int DEGREE = 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [23:0] in_sample,
  output logic out_valid,
  input  logic out_stall,
  output logic [31:0] out_position,
  output logic signed [23:0] out_smoothed_value,
  output logic out_last_of_run
);
  localparam int IW = $clog2(SPAN + 1);

  typedef logic [SPAN:0][SPAN:0][SPAN:0][sgs_pkg::CoefW-1:0] coef_rom_t;

  // coefficient rom indexed by window, row and tap, zero outside the window
  function automatic coef_rom_t build_rom();
    coef_rom_t r;
    r = '0;
    for (int w = 1; w <= SPAN; w++)
      for (int i = 0; i < w; i++)
        for (int j = 0; j < w; j++)
          r[w][i][j] = sgs_pkg::coef_f(w, i, j, DEGREE);
    return r;
  endfunction

  localparam coef_rom_t COEF_ROM = build_rom();

  sgs_pkg::state_t st_r, st_nxt;
  logic signed [23:0] hist_r [SPAN];
  logic [31:0] cnt_r;
  logic [IW-1:0] fill_r, w_r, cw_r, row_r, tap_r;
  logic [1:0] drain_r;
  logic signed [23:0] mac_res, byp_r;
  logic signed [sgs_pkg::CoefW-1:0] coef;
  sgs_pkg::mac_ctl_t ctl;
  logic [IW-1:0] fill_n, w_n;
  logic signed [23:0] smp;

  always_comb begin
    fill_n = (fill_r < IW'(SPAN)) ? fill_r + 1'b1 : fill_r;
    w_n = fill_n[0] ? fill_n : fill_n - 1'b1;
  end

  // coefficient lookup: window, row, tap
  assign coef = $signed(COEF_ROM[w_r][row_r][tap_r]);

  always_comb begin
    smp = hist_r[0];
    for (int k = 0; k < SPAN; k++)
      if (IW'(k) == IW'(SPAN) - w_r + tap_r) smp = hist_r[k];
  end

  // the sum is cleared only once its result has left
  assign ctl.clr = (st_r == sgs_pkg::ST_IDLE) ||
                   ((st_r == sgs_pkg::ST_OUT) && !out_stall);
  assign ctl.en  = (st_r == sgs_pkg::ST_MAC) && (tap_r < w_r);

  sgs_mac u_mac (.clk(clk), .ctl(ctl), .coef(coef), .smp(smp), .res(mac_res));

  assign in_stall = (st_r != sgs_pkg::ST_IDLE);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      sgs_pkg::ST_IDLE: if (in_valid)
        st_nxt = (w_n <= IW'(DEGREE)) ? sgs_pkg::ST_BYP : sgs_pkg::ST_MAC;
      sgs_pkg::ST_MAC: if (tap_r >= w_r && drain_r == 2'd2) st_nxt = sgs_pkg::ST_OUT;
      sgs_pkg::ST_OUT: if (!out_stall)
        st_nxt = (row_r == w_r - 1'b1) ? sgs_pkg::ST_IDLE : sgs_pkg::ST_MAC;
      sgs_pkg::ST_BYP: if (!out_stall) st_nxt = sgs_pkg::ST_IDLE;
      default: st_nxt = sgs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sgs_pkg::ST_IDLE;
      cnt_r <= '0;
      fill_r <= '0;
      cw_r <= '0;
      tap_r <= '0;
      drain_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == sgs_pkg::ST_IDLE && in_valid) begin
        for (int k = 0; k < SPAN - 1; k++) hist_r[k] <= hist_r[k+1];
        hist_r[SPAN-1] <= in_sample;
        byp_r <= in_sample;
        cnt_r <= cnt_r + 1'b1;
        fill_r <= fill_n;
        w_r <= w_n;
        tap_r <= '0;
        drain_r <= '0;
        if (w_n > IW'(DEGREE)) begin
          row_r <= (w_n != cw_r) ? '0 : (w_n - 1'b1) >> 1;
          cw_r <= w_n;
        end
      end
      if (st_r == sgs_pkg::ST_MAC) begin
        if (tap_r < w_r) tap_r <= tap_r + 1'b1;
        else drain_r <= drain_r + 1'b1;
      end
      if (st_r == sgs_pkg::ST_OUT && !out_stall) begin
        row_r <= row_r + 1'b1;
        tap_r <= '0;
        drain_r <= '0;
      end
    end
  end

  assign out_valid = (st_r == sgs_pkg::ST_OUT) || (st_r == sgs_pkg::ST_BYP);
  assign out_smoothed_value = (st_r == sgs_pkg::ST_BYP) ? byp_r : mac_res;
  assign out_position = (st_r == sgs_pkg::ST_BYP) ? cnt_r - 1'b1 :
                        cnt_r - 32'(w_r) + 32'(row_r);
  assign out_last_of_run = (st_r == sgs_pkg::ST_BYP) || (row_r == w_r - 1'b1);

  `SGS_ASSERT_IMPL(a_busy_stall, clk, rst_n, out_valid, in_stall)
  `SGS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `SGS_ASSERT_IMPL(a_oh, clk, rst_n, 1'b1, $onehot(st_r))
endmodule

>>> sv/sgs_mac.sv
module sgs_mac (
  input  logic clk,
  input  sgs_pkg::mac_ctl_t ctl,
  input  logic signed [sgs_pkg::CoefW-1:0] coef,
  input  logic signed [sgs_pkg::SampleW-1:0] smp,
  output logic signed [sgs_pkg::SampleW-1:0] res
);
  logic signed [sgs_pkg::AccW-1:0] prod_r, acc_r, rnd;
  logic pv_r;

  // one product per cycle, registered before the add
  always_ff @(posedge clk) begin
    prod_r <= sgs_pkg::AccW'(coef) * sgs_pkg::AccW'(smp);
    pv_r <= ctl.en;
    if (ctl.clr) acc_r <= '0;
    else if (pv_r) acc_r <= acc_r + prod_r;
  end

  always_comb begin
    rnd = (acc_r + sgs_pkg::AccW'(32768)) >>> 16;
    if (rnd > sgs_pkg::AccW'(8388607)) res = 24'sh7fffff;
    else if (rnd < -sgs_pkg::AccW'(8388608)) res = 24'sh800000;
    else res = rnd[sgs_pkg::SampleW-1:0];
  end
endmodule
